// File: rtl/assert_macros.svh
// assertion macros used by rdt_core
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

// File: rtl/rdt_pkg.sv
// types and constants for the replication dormancy tracker
// no dependencies
package rdt_pkg;
   typedef enum logic [2:0] {
      OP_REGISTER = 3'd0, OP_DIRTY = 3'd1, OP_DORMANT = 3'd2, OP_REMOVE_ENT = 3'd3,
      OP_EVALUATE = 3'd4, OP_ACK = 3'd5, OP_REMOVE_CONN = 3'd6, OP_QUERY = 3'd7
   } op_type;
   typedef enum logic [1:0] {
      ACT_NONE = 2'd0, ACT_DESPAWN = 2'd1, ACT_SNAPSHOT = 2'd2, ACT_DELTA = 2'd3
   } action_type;
   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] generation;
      logic [63:0] baseline;
      logic        woke;
      logic        accepted;
      logic        dormant;
   } result_type;
endpackage

// File: rtl/rdt_core.sv
// sequencer of the tracker: entity memory and link memory, read-modify-write
// depends on rdt_pkg and assert_macros.svh
module rdt_core #(
   parameter int ENTITY_COUNT = 256,
   parameter int CONNECTION_COUNT = 16,
   parameter int GENERATION_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2:0]            operation,
   input  logic [7:0]            entity_index,
   input  logic [3:0]            connection_index,
   input  logic                  flag_in,
   input  logic [31:0]           ack_generation,
   input  logic [63:0]           ack_baseline,
   output logic                  busy,
   output logic                  done,
   output rdt_pkg::result_type   result
);
   import rdt_pkg::*;
   `include "assert_macros.svh"

   localparam int EB = (ENTITY_COUNT > 1) ? $clog2(ENTITY_COUNT) : 1;
   localparam int CB = (CONNECTION_COUNT > 1) ? $clog2(CONNECTION_COUNT) : 1;
   localparam int LB = EB + CB;
   localparam int GB = GENERATION_BITS;
   localparam int EW = 1 + 2 * GB;
   localparam int LW = 1 + GB + 64;
   localparam logic [GB-1:0] GEN_MAX = '1;

   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_EXEC, S_SWEEP, S_DONE} state_type;

   logic [EW-1:0] ent_mem [ENTITY_COUNT];
   logic [LW-1:0] link_mem [2**LB];
   logic [ENTITY_COUNT-1:0] valid_ff;

   state_type state_ff;
   op_type op_ff;
   logic [EB-1:0] e_ff;
   logic [CB-1:0] c_ff;
   logic e_ok_ff, c_ok_ff, flag_ff;
   logic [GB-1:0] ackg_ff;
   logic [63:0] ackb_ff;
   logic [EW-1:0] ent_rd_ff;
   logic [LW-1:0] link_rd_ff;
   logic [LB:0] sweep_ff;
   result_type res_ff;

   logic e_ok, c_ok;
   logic [LB-1:0] li;
   assign e_ok = {24'd0, entity_index} < 32'(ENTITY_COUNT);
   assign c_ok = {28'd0, connection_index} < 32'(CONNECTION_COUNT);
   assign li = {c_ff, e_ff};

   logic ent_we, link_we;
   logic [EW-1:0] ent_wd;
   logic [LW-1:0] link_wd;
   logic [LB-1:0] clear_idx;
   logic clear_en;
   result_type res_in;
   logic set_valid, clr_valid;

   logic ev, lint;
   logic ent_dorm;
   logic [GB-1:0] g, wg, ng, lack;
   logic [63:0] lbase;

   always_comb begin
      ev = valid_ff[e_ff];
      lint = link_rd_ff[LW-1];
      ent_dorm = ev ? ent_rd_ff[EW-1] : 1'b0;
      g = ev ? ent_rd_ff[2*GB-1:GB] : '0;
      wg = ev ? ent_rd_ff[GB-1:0] : '0;
      ng = (g < GEN_MAX) ? g + 1'b1 : g;
      lack = link_rd_ff[LW-2:64];
      lbase = link_rd_ff[63:0];
      ent_we = 1'b0; link_we = 1'b0;
      ent_wd = {ent_dorm, g, wg};
      link_wd = '0;
      res_in = '0;
      set_valid = 1'b0; clr_valid = 1'b0;
      case (op_ff)
         OP_REGISTER: if (e_ok_ff) begin
            ent_we = 1'b1; set_valid = 1'b1;
            res_in.generation = 32'(g);
         end
         OP_DIRTY: if (e_ok_ff) begin
            ent_we = 1'b1; set_valid = 1'b1;
            ent_wd = {1'b0, ng, ent_dorm ? ng : wg};
            res_in.generation = 32'(ng);
         end
         OP_DORMANT: if (e_ok_ff) begin
            ent_we = 1'b1; set_valid = 1'b1;
            ent_wd = {flag_ff, g, wg};
         end
         OP_REMOVE_ENT: if (e_ok_ff) clr_valid = 1'b1;
         OP_EVALUATE: if (e_ok_ff && c_ok_ff && ev) begin
            if (!flag_ff) begin
               res_in.action = lint ? ACT_DESPAWN : ACT_NONE;
               res_in.generation = 32'(g);
               link_we = 1'b1;
            end else if (!lint) begin
               link_we = 1'b1;
               link_wd = {1'b1, (LW-1)'(0)};
               res_in.action = ACT_SNAPSHOT;
               res_in.generation = 32'(g);
               res_in.woke = wg == g;
            end else if (lack < g) begin
               res_in.baseline = lbase;
               res_in.action = (lbase == 64'd0) ? ACT_SNAPSHOT : ACT_DELTA;
               res_in.generation = 32'(g);
               res_in.woke = wg == g;
            end
         end
         OP_ACK: if (e_ok_ff && c_ok_ff && ev && lint && ackg_ff >= lack && ackg_ff <= g
                     && ackb_ff != 64'd0) begin
            link_we = 1'b1;
            link_wd = {1'b1, ackg_ff, ackb_ff};
            res_in.accepted = 1'b1;
         end
         OP_QUERY: if (e_ok_ff && ev) begin
            res_in.generation = 32'(g);
            res_in.dormant = ent_dorm;
         end
         default: ;
      endcase
   end

   // sweeps and the reset pass clear link entries one a cycle
   always_comb begin
      clear_en = 1'b0;
      clear_idx = '0;
      if (state_ff == S_CLEAR) begin
         clear_en = 1'b1;
         clear_idx = sweep_ff[LB-1:0];
      end else if (state_ff == S_SWEEP) begin
         clear_en = 1'b1;
         if (op_ff == OP_REMOVE_ENT) clear_idx = {sweep_ff[CB-1:0], e_ff};
         else clear_idx = {c_ff, sweep_ff[EB-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      ent_rd_ff <= ent_mem[e_ff];
      link_rd_ff <= link_mem[li];
      if (state_ff == S_EXEC && ent_we) ent_mem[e_ff] <= ent_wd;
      if (state_ff == S_EXEC && link_we) link_mem[li] <= link_wd;
      else if (clear_en) link_mem[clear_idx] <= '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         valid_ff <= '0;
         sweep_ff <= '0;
         op_ff <= OP_QUERY;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == (LB+1)'(2**LB - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (start) begin
               op_ff <= op_type'(operation);
               e_ff <= EB'(entity_index);
               c_ff <= CB'(connection_index);
               e_ok_ff <= e_ok; c_ok_ff <= c_ok;
               flag_ff <= flag_in;
               ackg_ff <= GB'(ack_generation);
               ackb_ff <= ack_baseline;
               state_ff <= S_READ;
            end
            S_READ: state_ff <= S_EXEC;
            S_EXEC: begin
               res_ff <= res_in;
               if (set_valid) valid_ff[e_ff] <= 1'b1;
               if (clr_valid) valid_ff[e_ff] <= 1'b0;
               sweep_ff <= '0;
               if ((op_ff == OP_REMOVE_ENT && e_ok_ff) || (op_ff == OP_REMOVE_CONN && c_ok_ff))
                  state_ff <= S_SWEEP;
               else state_ff <= S_DONE;
            end
            S_SWEEP: begin
               sweep_ff <= sweep_ff + 1'b1;
               if ((op_ff == OP_REMOVE_ENT && sweep_ff == (LB+1)'(CONNECTION_COUNT - 1)) ||
                   (op_ff == OP_REMOVE_CONN && sweep_ff == (LB+1)'(ENTITY_COUNT - 1)))
                  state_ff <= S_DONE;
            end
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = state_ff != S_IDLE;
   assign done = state_ff == S_DONE;
   assign result = res_ff;

   `ASSERT_NEXT(a_start_reads, clock, reset, state_ff == S_IDLE && start, state_ff == S_READ)
   `ASSERT_IMPLIES(a_ack_only, clock, reset, state_ff == S_EXEC && res_in.accepted,
      op_ff == OP_ACK)
   `ASSERT_IMPLIES(a_done_single, clock, reset, done, !(state_ff == S_IDLE))
endmodule

// File: rtl/replication_dormancy_tracker.sv
// response: after the request transaction the core passes the read, execute and done states,
// with a link sweep of CONNECTION_COUNT entries for remove entity or ENTITY_COUNT entries
// for remove connection; rsp_tvalid is registered from done; one request at a time: a new
// request is accepted no earlier than the cycle after the response transaction
// reset: synchronous active high, clears entity valid bits at once, then clears the link
// memory one entry a cycle (4096 entries by default) with req_tready low; depends on rdt_core
module replication_dormancy_tracker #(
   parameter int ENTITY_COUNT = 256,
   parameter int CONNECTION_COUNT = 16,
   parameter int GENERATION_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // operation[2:0], entity_index[10:3], connection_index[14:11], flag_in[15],
   // ack_generation[47:16], ack_baseline[111:48]
   input  logic [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // action[1:0], generation_out[33:2], baseline_out[97:34], woke[98],
   // accepted[99], dormant_out[100], zero fill to 104
   output logic [103:0] rsp_tdata
);
   import rdt_pkg::*;

   logic busy, done, start;
   result_type res;
   logic rv_ff;
   logic [103:0] rd_ff;

   assign req_tready = !busy && !rv_ff;
   assign start = req_tvalid && req_tready;

   rdt_core #(.ENTITY_COUNT(ENTITY_COUNT), .CONNECTION_COUNT(CONNECTION_COUNT),
      .GENERATION_BITS(GENERATION_BITS)) u_core (
      .clock, .reset, .start,
      .operation(req_tdata[2:0]), .entity_index(req_tdata[10:3]),
      .connection_index(req_tdata[14:11]), .flag_in(req_tdata[15]),
      .ack_generation(req_tdata[47:16]), .ack_baseline(req_tdata[111:48]),
      .busy, .done, .result(res));

   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (done) rv_ff <= 1'b1;
      else if (rsp_tready) rv_ff <= 1'b0;
      if (done) rd_ff <= {3'd0, res.dormant, res.accepted, res.woke, res.baseline,
         res.generation, res.action};
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = rd_ff;
endmodule
